// ----- hw/rtl/knnwc_pkg.sv -----
// shared types, widths and constants for the knn weighted centroid unit
package knnwc_pkg;

    localparam int MAX_K_DEF = 8;

    localparam int DIST_W = 16;
    localparam int POS_W  = 8;
    localparam int SQ_W   = 32;
    localparam int WGT_W  = 33;
    localparam int PROD_W = 49;
    localparam int WSUM_W = 37;
    localparam int ACC_W  = 53;
    localparam int EST_W  = 16;
    localparam int REM_W  = 38;
    localparam int QCNT_W = 6;

    localparam logic [15:0] TARGET_RSSI_RST     = 16'd40648;
    localparam logic [3:0]  NEIGHBOUR_COUNT_RST = 4'd4;

    localparam logic [1:0] CFG_TARGET_RSSI     = 2'd0;
    localparam logic [1:0] CFG_NEIGHBOUR_COUNT = 2'd1;

    localparam logic [1:0] STATUS_WEIGHTED = 2'd0;
    localparam logic [1:0] STATUS_EXACT    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    typedef struct packed {
        logic              en;
        logic [DIST_W-1:0] distance;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
    } kl_ins_t;

endpackage

// ----- hw/rtl/knnwc_kept_list.sv -----
// sorted list of the nearest references, stable insertion
module knnwc_kept_list #(
    parameter int MAX_K = knnwc_pkg::MAX_K_DEF,
    parameter int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1,
    parameter int CNT_W = $clog2(MAX_K + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  knnwc_pkg::kl_ins_t         ins,
    input  logic                       clr,
    input  logic [IDX_W-1:0]           rd_idx,
    output logic [knnwc_pkg::DIST_W-1:0] rd_dist,
    output logic [knnwc_pkg::POS_W-1:0]  rd_x,
    output logic [knnwc_pkg::POS_W-1:0]  rd_y,
    output logic [knnwc_pkg::DIST_W-1:0] head_dist,
    output logic [knnwc_pkg::POS_W-1:0]  head_x,
    output logic [knnwc_pkg::POS_W-1:0]  head_y,
    output logic [CNT_W-1:0]           count
);
    import knnwc_pkg::*;

    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_K);

    logic [DIST_W-1:0] dist_reg [MAX_K];
    logic [POS_W-1:0]  x_reg    [MAX_K];
    logic [POS_W-1:0]  y_reg    [MAX_K];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAX_K-1:0]  le;

    // entry stays where it is when it is kept and not above the new distance
    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (dist_reg[i] <= ins.distance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins.en)
        begin
            for (int i = 0; i < MAX_K; i++)
            begin
                if (!le[i])
                begin
                    if (i == 0 || le[(i == 0) ? 0 : i - 1])
                    begin
                        dist_reg[i] <= ins.distance;
                        x_reg[i]    <= ins.x;
                        y_reg[i]    <= ins.y;
                    end
                    else
                    begin
                        dist_reg[i] <= dist_reg[(i == 0) ? 0 : i - 1];
                        x_reg[i]    <= x_reg[(i == 0) ? 0 : i - 1];
                        y_reg[i]    <= y_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (clr)
        begin
            count_next = '0;
        end
        else if (ins.en && count_reg < FULL)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_dist   = dist_reg[rd_idx];
    assign rd_x      = x_reg[rd_idx];
    assign rd_y      = y_reg[rd_idx];
    assign head_dist = dist_reg[0];
    assign head_x    = x_reg[0];
    assign head_y    = y_reg[0];
    assign count     = count_reg;

endmodule

// ----- hw/rtl/knnwc_div.sv -----
// shared restoring divider, one quotient bit per cycle
module knnwc_div #(
    parameter int REM_W = knnwc_pkg::REM_W,
    parameter int DEN_W = knnwc_pkg::WSUM_W,
    parameter int SH_W  = knnwc_pkg::WGT_W,
    parameter int CNT_W = knnwc_pkg::QCNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] cnt_init,
    input  logic [REM_W-1:0] rem_init,
    input  logic [SH_W-1:0]  bits_init,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [SH_W-1:0]  quo
);
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [SH_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign trial = {rem_reg[REM_W-2:0], sh_reg[SH_W-1]};
    assign ge    = trial >= REM_W'(den_reg);

    always_comb
    begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = rem_init;
            sh_next  = bits_init;
            quo_next = '0;
            den_next = den;
            cnt_next = cnt_init;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? trial - REM_W'(den_reg) : trial;
            sh_next  = {sh_reg[SH_W-2:0], 1'b0};
            quo_next = {quo_reg[SH_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

// ----- hw/rtl/knn_rssi_weighted_centroid_unit.sv -----
// top level: knn rssi weighted centroid estimator with its sequencer
// Reference tags come in on the input channel (in_valid/in_ready), one beat
// per reference: ref_rssi, ref_x, ref_y and is_last. Each is kept in a sorted
// list of the nearest references by |ref_rssi - target_rssi|; ties keep the
// earlier reference first. After a beat the list takes the reference in
// S_INS, and in_ready only rises again back in S_IDLE. The beat with is_last
// set starts the estimate: for each of the used entries one squaring, a
// 33-bit weight divide and two multiply-adds run on the shared multiplier
// and shared bit-serial divider, then two 16-bit divides give est_x and
// est_y, the divider taking one quotient bit per cycle; an exact match
// skips the divides and gives the head entry's position as its result.
// The result beat (est_x, est_y, used_count, status) sits in an output
// register until out_ready; a new reference may be taken meanwhile, and the
// sequencer only waits when its next result finds the register still full.
// Configuration (cfg_we, cfg_idx, cfg_wdata) is to be written by the user
// only while idle; the block does not enforce it. Index 0 is target_rssi,
// index 1 neighbour_count; other indexes are ignored. Reset empties the
// list, drops any pending result and restores the register defaults.
module knn_rssi_weighted_centroid_unit #(
    parameter int MAX_K = knnwc_pkg::MAX_K_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] ref_rssi,
    input  logic [7:0]  ref_x,
    input  logic [7:0]  ref_y,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] est_x,
    output logic [15:0] est_y,
    output logic [3:0]  used_count,
    output logic [1:0]  status
);
    import knnwc_pkg::*;

    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam logic [4:0] MAXK5 = 5'(MAX_K);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INS   = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_DM2   = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_WST   = 4'd5;
    localparam logic [3:0] S_WWT   = 4'd6;
    localparam logic [3:0] S_MX    = 4'd7;
    localparam logic [3:0] S_AX    = 4'd8;
    localparam logic [3:0] S_AY    = 4'd9;
    localparam logic [3:0] S_EXS   = 4'd10;
    localparam logic [3:0] S_EXW   = 4'd11;
    localparam logic [3:0] S_EYS   = 4'd12;
    localparam logic [3:0] S_EYW   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    localparam logic [QCNT_W-1:0] WGT_BITS = QCNT_W'(WGT_W);
    localparam logic [QCNT_W-1:0] EST_BITS = QCNT_W'(EST_W);

    logic [3:0]        state_reg, state_next;
    logic [15:0]       target_reg;
    logic [3:0]        ncount_reg;

    logic [DIST_W-1:0] in_dist_reg;
    logic [POS_W-1:0]  in_x_reg, in_y_reg;
    logic              in_last_reg;
    logic [DIST_W-1:0] in_dist;

    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SQ_W-1:0]   dm2_reg, dm2_next;
    logic [WGT_W-1:0]  w_reg, w_next;
    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [ACC_W-1:0]  nx_reg, nx_next, ny_reg, ny_next;
    logic [EST_W-1:0]  ex_reg, ex_next, ey_reg, ey_next;
    logic [1:0]        st_reg, st_next;

    logic              out_valid_reg, out_valid_next;
    logic [EST_W-1:0]  oex_reg, oey_reg;
    logic [3:0]        oused_reg;
    logic [1:0]        ost_reg;
    logic              load_out;

    logic [DIST_W-1:0] mul_a;
    logic [WGT_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    kl_ins_t           ins;
    logic              kl_clr;
    logic [DIST_W-1:0] rd_dist, head_dist;
    logic [POS_W-1:0]  rd_x, rd_y, head_x, head_y;
    logic [CNT_W-1:0]  kept;

    logic              div_start, div_busy;
    logic [QCNT_W-1:0] div_cnt;
    logic [REM_W-1:0]  div_rem;
    logic [WGT_W-1:0]  div_bits, div_quo;
    logic [WSUM_W-1:0] div_den;
    logic [ACC_W-1:0]  est_num;
    logic [ACC_W-1:0]  est_num_y;

    logic [4:0]        k5;
    logic [CNT_W-1:0]  kval;

    assign in_ready = (state_reg == S_IDLE);
    assign in_dist  = (ref_rssi >= target_reg) ? ref_rssi - target_reg : target_reg - ref_rssi;

    always_comb
    begin
        if (ncount_reg == 4'd0)
        begin
            k5 = 5'd1;
        end
        else if ({1'b0, ncount_reg} > MAXK5)
        begin
            k5 = MAXK5;
        end
        else
        begin
            k5 = {1'b0, ncount_reg};
        end
        kval = CNT_W'(k5);
    end

    assign ins.en       = (state_reg == S_INS);
    assign ins.distance = in_dist_reg;
    assign ins.x        = in_x_reg;
    assign ins.y        = in_y_reg;

    knnwc_kept_list #(
        .MAX_K (MAX_K),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .ins       (ins),
        .clr       (kl_clr),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_dist   (rd_dist),
        .rd_x      (rd_x),
        .rd_y      (rd_y),
        .head_dist (head_dist),
        .head_x    (head_x),
        .head_y    (head_y),
        .count     (kept)
    );

    // numerator for the final divides, rounding to nearest
    assign est_num   = nx_reg + ACC_W'(wsum_reg >> 1);
    assign est_num_y = ny_reg + ACC_W'(wsum_reg >> 1);

    always_comb
    begin
        div_start = 1'b0;
        div_cnt   = WGT_BITS;
        div_rem   = REM_W'(dm2_reg >> 1);
        div_bits  = {dm2_reg[0], {(WGT_W-1){1'b0}}};
        div_den   = WSUM_W'(prod_reg[SQ_W-1:0]);
        if (state_reg == S_WST)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_EXS || state_reg == S_EYS)
        begin
            div_start = 1'b1;
            div_cnt   = EST_BITS;
            div_den   = wsum_reg;
            if (state_reg == S_EXS)
            begin
                div_rem  = REM_W'(est_num[ACC_W-1:EST_W]);
                div_bits = {est_num[EST_W-1:0], {(WGT_W-EST_W){1'b0}}};
            end
            else
            begin
                div_rem  = REM_W'(est_num_y[ACC_W-1:EST_W]);
                div_bits = {est_num_y[EST_W-1:0], {(WGT_W-EST_W){1'b0}}};
            end
        end
    end

    knnwc_div #(
        .REM_W (REM_W),
        .DEN_W (WSUM_W),
        .SH_W  (WGT_W),
        .CNT_W (QCNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .cnt_init  (div_cnt),
        .rem_init  (div_rem),
        .bits_init (div_bits),
        .den       (div_den),
        .busy      (div_busy),
        .quo       (div_quo)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = rd_dist;
        mul_b = WGT_W'(rd_dist);
        case (state_reg)
            S_EVAL:  begin mul_a = head_dist;         mul_b = WGT_W'(head_dist); end
            S_MX:    begin mul_a = {rd_x, 8'h00};      mul_b = w_reg;             end
            S_AX:    begin mul_a = {rd_y, 8'h00};      mul_b = w_reg;             end
            default: begin mul_a = rd_dist;           mul_b = WGT_W'(rd_dist);   end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        prod_next  = prod_reg;
        dm2_next   = dm2_reg;
        w_next     = w_reg;
        wsum_next  = wsum_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        st_next    = st_reg;
        load_out   = 1'b0;
        kl_clr     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                state_next = in_last_reg ? S_EVAL : S_IDLE;
            end
            S_EVAL:
            begin
                used_next = (kept < kval) ? kept : kval;
                idx_next  = '0;
                wsum_next = '0;
                nx_next   = '0;
                ny_next   = '0;
                prod_next = mul_p;
                if (kept == '0)
                begin
                    ex_next    = '0;
                    ey_next    = '0;
                    st_next    = STATUS_EMPTY;
                    state_next = S_FIN;
                end
                else if (head_dist == '0)
                begin
                    ex_next    = {head_x, 8'h00};
                    ey_next    = {head_y, 8'h00};
                    st_next    = STATUS_EXACT;
                    state_next = S_FIN;
                end
                else
                begin
                    st_next    = STATUS_WEIGHTED;
                    state_next = S_DM2;
                end
            end
            S_DM2:
            begin
                dm2_next   = prod_reg[SQ_W-1:0];
                state_next = S_SQ;
            end
            S_SQ:
            begin
                prod_next  = mul_p;
                state_next = S_WST;
            end
            S_WST:
            begin
                state_next = S_WWT;
            end
            S_WWT:
            begin
                if (!div_busy)
                begin
                    w_next     = div_quo;
                    state_next = S_MX;
                end
            end
            S_MX:
            begin
                prod_next  = mul_p;
                state_next = S_AX;
            end
            S_AX:
            begin
                nx_next    = nx_reg + ACC_W'(prod_reg);
                prod_next  = mul_p;
                state_next = S_AY;
            end
            S_AY:
            begin
                ny_next    = ny_reg + ACC_W'(prod_reg);
                wsum_next  = wsum_reg + WSUM_W'(w_reg);
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg + 1'b1 == used_reg) ? S_EXS : S_SQ;
            end
            S_EXS:
            begin
                state_next = S_EXW;
            end
            S_EXW:
            begin
                if (!div_busy)
                begin
                    ex_next    = div_quo[EST_W-1:0];
                    state_next = S_EYS;
                end
            end
            S_EYS:
            begin
                state_next = S_EYW;
            end
            S_EYW:
            begin
                if (!div_busy)
                begin
                    ey_next    = div_quo[EST_W-1:0];
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    kl_clr     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= TARGET_RSSI_RST;
            ncount_reg    <= NEIGHBOUR_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_idx == CFG_TARGET_RSSI)
            begin
                target_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_idx == CFG_NEIGHBOUR_COUNT)
            begin
                ncount_reg <= cfg_wdata[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_dist_reg <= in_dist;
            in_x_reg    <= ref_x;
            in_y_reg    <= ref_y;
            in_last_reg <= is_last;
        end
        used_reg <= used_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        dm2_reg  <= dm2_next;
        w_reg    <= w_next;
        wsum_reg <= wsum_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        st_reg   <= st_next;
        if (load_out)
        begin
            oex_reg   <= ex_reg;
            oey_reg   <= ey_reg;
            oused_reg <= 4'(used_reg);
            ost_reg   <= st_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign est_x      = oex_reg;
    assign est_y      = oey_reg;
    assign used_count = oused_reg;
    assign status     = ost_reg;

endmodule
